FILE: hdl/ffac_pkg.sv
package ffac_pkg;

	// Store geometry and field widths.
	localparam int CAPACITY   = 16;
	localparam int ADDR_BITS  = 32;
	localparam int DATA_BITS  = 32;
	localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);
	localparam int CFG_BITS   = 5;

	localparam logic [CFG_BITS-1:0] CAP_RESET = CFG_BITS'(16);

	// Request codes.
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_PUT   = 2'd2;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [ADDR_BITS-1:0] addr;
		logic [DATA_BITS-1:0] data;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic [DATA_BITS-1:0] read_data;
		logic                 evicted;
		logic [ADDR_BITS-1:0] evicted_addr;
		logic [DATA_BITS-1:0] evicted_data;
		logic                 evicted_synced;
	} rsp_t;

	// One stored line.
	typedef struct packed {
		logic [ADDR_BITS-1:0] tag;
		logic [DATA_BITS-1:0] word;
		logic                 synced;
	} entry_t;

	// Access commands from the sequencer to the entry store.
	typedef struct packed {
		logic                 rd_en;
		logic [SLOT_BITS-1:0] rd_slot;
		logic                 wr_en;
		logic [SLOT_BITS-1:0] wr_slot;
		logic                 clr_en;
		logic [SLOT_BITS-1:0] clr_slot;
	} store_cmd_t;

endpackage

FILE: hdl/fifo_fully_associative_cache_unit.sv
// Fully associative cache with FIFO replacement, one request at a time.
// A request (read, write or put) is a transfer on req_valid/req_ready; each
// request gives exactly one response transfer on rsp_valid/rsp_ready.
// The lookup scans every slot through one tag comparator, one slot per
// cycle behind the registered read port of the entry memory. A request
// that allocates also passes through a write step, and one whose
// allocation evicts the oldest entry first passes through an eviction step.
// An unused request code answers with all-zero fields. The next request
// can be taken in the cycle after the response is loaded.
// The response sits in an output register: a stalled receiver does not keep
// the next request out, but a second response waits until the first is
// taken. The capacity register is written by cfg_we/cfg_wdata, which the
// user must assert only while idle; the block does not enforce this.
// Reset empties the cache (all valid bits cleared at once, no clearing
// pass), sets the capacity to 16 and drops any pending response.
module fifo_fully_associative_cache_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  ffac_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output ffac_pkg::rsp_t                       rsp,
	input  logic                                 cfg_we,
	input  logic [ffac_pkg::CFG_BITS-1:0]        cfg_wdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_EVCAP  = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	localparam logic [ffac_pkg::COUNT_BITS-1:0] CAP_COUNT =
		ffac_pkg::COUNT_BITS'(ffac_pkg::CAPACITY);

	logic [2:0]                          state_q;
	logic [ffac_pkg::CFG_BITS-1:0]       cap_q;
	logic [ffac_pkg::SLOT_BITS-1:0]      oldest_q;
	logic [ffac_pkg::COUNT_BITS-1:0]     fill_q;
	logic [ffac_pkg::COUNT_BITS-1:0]     scan_q;
	logic                                cmp_vld_q;
	logic [ffac_pkg::SLOT_BITS-1:0]      cmp_slot_q;
	logic                                rsp_valid_q;
	ffac_pkg::rsp_t                      rsp_q;

	ffac_pkg::req_t                      req_q;
	logic                                hit_q;
	logic [ffac_pkg::SLOT_BITS-1:0]      hit_slot_q;
	logic [ffac_pkg::DATA_BITS-1:0]      rdata_q;
	logic                                ev_q;
	ffac_pkg::entry_t                    ev_entry_q;

	ffac_pkg::store_cmd_t                store_cmd;
	ffac_pkg::entry_t                    wr_entry;
	ffac_pkg::entry_t                    rd_entry;
	logic                                rd_valid;

	logic [ffac_pkg::COUNT_BITS-1:0]     eff_cap;
	logic                                full;
	logic [ffac_pkg::COUNT_BITS:0]       alloc_sum;
	logic [ffac_pkg::COUNT_BITS:0]       alloc_wrap;
	logic [ffac_pkg::SLOT_BITS-1:0]      alloc_slot;
	logic [ffac_pkg::SLOT_BITS-1:0]      oldest_next;
	logic                                tag_match;
	logic                                req_xfer;

	ffac_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (store_cmd),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Capacity clamped to the range 1 .. CAPACITY.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = ffac_pkg::COUNT_BITS'(1);
		end else if (int'(cap_q) > ffac_pkg::CAPACITY) begin
			eff_cap = CAP_COUNT;
		end else begin
			eff_cap = ffac_pkg::COUNT_BITS'(cap_q);
		end
	end

	assign full = (fill_q >= eff_cap);

	// Next free ring slot is the oldest slot plus the fill, wrapped once.
	assign alloc_sum  = (ffac_pkg::COUNT_BITS+1)'(oldest_q)
		+ (ffac_pkg::COUNT_BITS+1)'(fill_q);
	assign alloc_wrap = (alloc_sum >= (ffac_pkg::COUNT_BITS+1)'(ffac_pkg::CAPACITY))
		? alloc_sum - (ffac_pkg::COUNT_BITS+1)'(ffac_pkg::CAPACITY) : alloc_sum;
	assign alloc_slot = alloc_wrap[ffac_pkg::SLOT_BITS-1:0];

	assign oldest_next = (int'(oldest_q) == ffac_pkg::CAPACITY - 1)
		? '0 : oldest_q + ffac_pkg::SLOT_BITS'(1);

	// The shared tag comparator looks at the slot read in the previous cycle.
	assign tag_match = cmp_vld_q && rd_valid && (rd_entry.tag == req_q.addr);

	// Whole entry written on a hit update or on an allocation.
	assign wr_entry = '{tag: req_q.addr, word: req_q.data,
		synced: (req_q.req_type == ffac_pkg::REQ_PUT)};

	// Store commands for each sequencer step.
	always_comb begin
		store_cmd = '0;
		unique case (state_q)
			ST_SCAN: begin
				store_cmd.rd_en   = (scan_q < CAP_COUNT);
				store_cmd.rd_slot = scan_q[ffac_pkg::SLOT_BITS-1:0];
			end
			ST_DECIDE: begin
				if (hit_q && req_q.req_type != ffac_pkg::REQ_READ) begin
					store_cmd.wr_en   = 1'b1;
					store_cmd.wr_slot = hit_slot_q;
				end else begin
					store_cmd.rd_en   = 1'b1;
					store_cmd.rd_slot = oldest_q;
				end
			end
			ST_EVCAP: begin
				store_cmd.clr_en   = 1'b1;
				store_cmd.clr_slot = oldest_q;
			end
			ST_WRITE: begin
				store_cmd.wr_en   = 1'b1;
				store_cmd.wr_slot = alloc_slot;
			end
			default: begin
				store_cmd = '0;
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= ffac_pkg::CAP_RESET;
			oldest_q    <= '0;
			fill_q      <= '0;
			scan_q      <= '0;
			cmp_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// The response register is loaded when the sequencer finishes and
			// emptied by a transfer.
			if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			cmp_vld_q <= (state_q == ST_SCAN) && store_cmd.rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req.req_type == ffac_pkg::REQ_READ
							|| req.req_type == ffac_pkg::REQ_WRITE
							|| req.req_type == ffac_pkg::REQ_PUT) begin
							state_q <= ST_SCAN;
							scan_q  <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q == CAP_COUNT) begin
						state_q <= ST_DECIDE;
					end else begin
						scan_q <= scan_q + ffac_pkg::COUNT_BITS'(1);
					end
				end
				ST_DECIDE: begin
					if (hit_q || req_q.req_type == ffac_pkg::REQ_READ) begin
						state_q <= ST_DONE;
					end else if (full) begin
						state_q <= ST_EVCAP;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_EVCAP: begin
					oldest_q <= oldest_next;
					fill_q   <= fill_q - ffac_pkg::COUNT_BITS'(1);
					state_q  <= ST_WRITE;
				end
				ST_WRITE: begin
					fill_q  <= fill_q + ffac_pkg::COUNT_BITS'(1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request, lookup result and response payload.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_q      <= req;
			hit_q      <= 1'b0;
			rdata_q    <= '0;
			ev_q       <= 1'b0;
			ev_entry_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			cmp_slot_q <= scan_q[ffac_pkg::SLOT_BITS-1:0];
		end
		if (state_q == ST_SCAN && tag_match) begin
			hit_q      <= 1'b1;
			hit_slot_q <= cmp_slot_q;
			if (req_q.req_type == ffac_pkg::REQ_READ) begin
				rdata_q <= rd_entry.word;
			end
		end
		if (state_q == ST_EVCAP) begin
			ev_q       <= 1'b1;
			ev_entry_q <= rd_entry;
		end
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= '{hit: hit_q, read_data: rdata_q, evicted: ev_q,
				evicted_addr: ev_entry_q.tag, evicted_data: ev_entry_q.word,
				evicted_synced: ev_entry_q.synced};
		end
	end

	// The fill never exceeds the number of slots.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_COUNT)
		else $error("fill count exceeds the number of slots");

	// A response never reports both a hit and an eviction.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.evicted))
		else $error("response reports a hit and an eviction together");

	// Read data is only returned on a hit.
	a_data_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.read_data != '0) |-> rsp.hit)
		else $error("read data without a hit");

	// Once a request is taken the block is busy in the following cycle.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> !req_ready)
		else $error("request taken while a request is in progress");

endmodule

FILE: hdl/ffac_store.sv
module ffac_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffac_pkg::store_cmd_t cmd,
	input  ffac_pkg::entry_t     wr_entry,
	output ffac_pkg::entry_t     rd_entry,
	output logic                 rd_valid
);

	ffac_pkg::entry_t                     mem [0:ffac_pkg::CAPACITY-1];
	ffac_pkg::entry_t                     rd_entry_q;
	logic [ffac_pkg::CAPACITY-1:0]        valid_q;
	logic                                 rd_valid_q;

	// Entry memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_slot] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_entry_q <= mem[cmd.rd_slot];
		end
	end

	// Valid bits live in flops so that reset empties the store at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[cmd.rd_slot];
			end
			if (cmd.clr_en) begin
				valid_q[cmd.clr_slot] <= 1'b0;
			end
			if (cmd.wr_en) begin
				valid_q[cmd.wr_slot] <= 1'b1;
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule
